// ===== hdl/assert_macros.svh =====
// Assertion helpers included by circular_polling_list.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cpl_pkg.sv =====
`default_nettype none

package cpl_pkg;

    localparam int IN_CMD_W    = 3;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 32;
    localparam int OUT_COUNT_W = 5;
    localparam int OUT_STAT_W  = 2;

    localparam logic [IN_CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [IN_CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [IN_CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [IN_CMD_W-1:0] CMD_PEEK   = 3'd3;
    localparam logic [IN_CMD_W-1:0] CMD_REWIND = 3'd4;
    localparam logic [IN_CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [OUT_STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [OUT_STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [OUT_STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [IN_CMD_W-1:0]  cmd;
        logic [IN_DATA_W-1:0] data_in;
    } t_in;

    typedef struct packed {
        logic [OUT_DATA_W-1:0]  data_out;
        logic [OUT_COUNT_W-1:0] count;
        logic [OUT_STAT_W-1:0]  status;
    } t_out;

    // Per-cycle commands broadcast along the cell row.
    typedef struct packed {
        logic append;
        logic remove;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== hdl/cpl_cell.sv =====
`default_nettype none

module cpl_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int CUR_W      = 4
) (
    input  wire                    i_clk,
    input  cpl_pkg::t_cell_ctl     i_ctl,
    input  wire [CNT_W-1:0]        i_count,
    input  wire [CUR_W-1:0]        i_cursor,
    input  wire [DATA_WIDTH-1:0]   i_din,
    input  wire [DATA_WIDTH-1:0]   i_next_data,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic                   o_hit
);
    import cpl_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Load on append into the first free slot; pull from the neighbor to
    // close the gap when the entry at or below this slot is removed.
    always_comb begin
        n_data = r_data;
        if (i_ctl.append && (i_count == CNT_W'(IDX))) begin
            n_data = i_din;
        end else if (i_ctl.remove && (i_cursor <= CUR_W'(IDX))) begin
            n_data = i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = (i_cursor == CUR_W'(IDX));

endmodule

`default_nettype wire

// ===== hdl/circular_polling_list.sv =====
// circular_polling_list: ordered list of up to DEPTH entries with a
// round-robin cursor, one entry per cell in a row of cpl_cell instances.
// Input channel (i_in_valid / o_in_ready, payload i_in): one command per
// transaction - append, remove at cursor, read and advance, peek, rewind,
// clear. Output channel (o_out_valid / i_out_ready, payload o_out): exactly
// one result per command with data, count after the command, and status.
// The result is registered into r_out, or into the skid slot during a stall.
// Throughput: one command per cycle while o_in_ready is high; each command
// updates every cell, the count and the cursor together, and cells from the
// cursor onward shift one place toward the head on a remove.
// Reset: the list is empty, the cursor is zero, no result is pending. Cell
// contents are not reset; only entries below the count are ever read.
// Receiver stall: a two-entry output buffer holds the presented result plus
// one more, so one extra command is taken during a stall; after that
// o_in_ready drops until the receiver takes a transaction.
`default_nettype none

`include "assert_macros.svh"

module circular_polling_list #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_ready,
    input  cpl_pkg::t_in   i_in,
    output logic           o_out_valid,
    input  wire            i_out_ready,
    output cpl_pkg::t_out  o_out
);
    import cpl_pkg::*;

    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int CUR_W      = $clog2(DEPTH);
    localparam int CNT_PAD_W  = (CNT_W > OUT_COUNT_W) ? CNT_W : OUT_COUNT_W;
    localparam int DATA_PAD_W = (DATA_WIDTH > OUT_DATA_W) ? DATA_WIDTH : OUT_DATA_W;

    // List control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CUR_W-1:0] r_cursor;
    logic [CUR_W-1:0] n_cursor;

    // Output buffer: presented result plus one skid slot
    logic r_out_valid;
    logic r_skid_valid;
    t_out r_out;
    t_out r_skid;

    logic                  in_acc;
    logic                  out_take;
    logic                  is_empty;
    logic                  is_full;
    t_cell_ctl             cell_ctl;
    t_out                  res;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] sel_data;
    logic [DATA_PAD_W-1:0] sel_pad;
    logic [CNT_PAD_W-1:0]  count_pad;
    logic [CNT_W-1:0]      cursor_inc;
    logic [CNT_W-1:0]      count_dec;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic                  cell_hit  [DEPTH];

    assign o_in_ready  = !r_skid_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == CNT_W'(DEPTH));
    assign din        = DATA_WIDTH'(i_in.data_in);
    assign cursor_inc = CNT_W'(r_cursor) + 1'b1;
    assign count_dec  = r_count - 1'b1;

    // Row of cells; the last cell has no neighbor and holds on a remove
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] next_data;
        if (g == DEPTH - 1) begin : g_tail
            assign next_data = cell_data[g];
        end else begin : g_body
            assign next_data = cell_data[g + 1];
        end

        cpl_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .CUR_W      (CUR_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (cell_ctl),
            .i_count     (r_count),
            .i_cursor    (r_cursor),
            .i_din       (din),
            .i_next_data (next_data),
            .o_data      (cell_data[g]),
            .o_hit       (cell_hit[g])
        );
    end

    // Gather the entry at the cursor; exactly one cell matches
    always_comb begin
        sel_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_hit[i]) begin
                sel_data = sel_data | cell_data[i];
            end
        end
    end

    assign sel_pad = DATA_PAD_W'(sel_data);

    // Decode the command: next count and cursor, cell controls, result
    always_comb begin
        n_count           = r_count;
        n_cursor          = r_cursor;
        cell_ctl          = '0;
        res.data_out      = '0;
        res.status        = ST_OK;
        if (in_acc) begin
            case (i_in.cmd)
                CMD_APPEND: begin
                    if (is_full) begin
                        res.status = ST_FULL;
                    end else begin
                        cell_ctl.append = 1'b1;
                        n_count         = r_count + 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    if (is_empty) begin
                        res.status = ST_EMPTY;
                    end else begin
                        cell_ctl.remove = 1'b1;
                        n_count         = count_dec;
                        // wrap when the cursor falls off the shortened list
                        if (CNT_W'(r_cursor) >= count_dec) begin
                            n_cursor = '0;
                        end
                    end
                end
                CMD_READ: begin
                    if (is_empty) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.data_out = sel_pad[OUT_DATA_W-1:0];
                        if (cursor_inc >= r_count) begin
                            n_cursor = '0;
                        end else begin
                            n_cursor = cursor_inc[CUR_W-1:0];
                        end
                    end
                end
                CMD_PEEK: begin
                    if (is_empty) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.data_out = sel_pad[OUT_DATA_W-1:0];
                    end
                end
                CMD_REWIND: begin
                    n_cursor = '0;
                end
                CMD_CLEAR: begin
                    n_count  = '0;
                    n_cursor = '0;
                end
                default: begin
                    // unused codes: drop without effect
                end
            endcase
        end
        // report the count after the command
        count_pad = CNT_PAD_W'(n_count);
        res.count = count_pad[OUT_COUNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
        end else begin
            r_count  <= n_count;
            r_cursor <= n_cursor;
        end
    end

    // Output buffer: if the presented slot is empty or taken, refill it
    // from the skid slot or the new result, else hold it and fill the skid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (in_acc) begin
            r_skid <= res;
        end
    end

    `ASSERT_ALWAYS(a_cursor_in_list, i_clk, i_rst_n,
        (is_empty ? (r_cursor == '0) : (CNT_W'(r_cursor) < r_count)),
        "cursor outside the list")
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, (r_count <= CNT_W'(DEPTH)),
        "count above depth")
    `ASSERT_ALWAYS(a_skid_behind_out, i_clk, i_rst_n, (!r_skid_valid || r_out_valid),
        "skid slot filled while output slot empty")
    `ASSERT_NEXT(a_append_grows, i_clk, i_rst_n,
        (in_acc && (i_in.cmd == CMD_APPEND) && !is_full),
        (r_count == $past(r_count) + 1'b1),
        "append on a non-full list did not grow the count")

endmodule

`default_nettype wire

// ===== tb/sv/cpl_list_checker.sv =====
`default_nettype none

module cpl_list_checker #(
    parameter int DEPTH = 16
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            in_valid,
    input  wire            in_ready,
    input  cpl_pkg::t_in   in_txn,
    input  wire            out_valid,
    input  wire            out_ready,
    input  cpl_pkg::t_out  out_txn,
    output int             fail_count,
    output int             pending,
    output int             checked,
    output int             full_seen,
    output int             empty_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import cpl_pkg::*;

    localparam int CUR_W = $clog2(DEPTH);

    // Shadow copy of the list, its length and the polling cursor.
    logic [IN_DATA_W-1:0]   list_mem [DEPTH];
    logic [OUT_COUNT_W-1:0] list_len;
    logic [CUR_W-1:0]       cursor;

    t_out pending_results[$];

    // Apply one command to the shadow list and return the result it yields.
    function automatic t_out run_list_cmd(t_in c);
        t_out r;
        int   nxt;
        r        = '0;
        r.status = ST_OK;
        case (c.cmd)
            CMD_APPEND: begin
                if (list_len >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[list_len[CUR_W-1:0]] = c.data_in;
                    list_len = list_len + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // close the gap left at the cursor
                    for (int i = int'(cursor); i + 1 < int'(list_len); i++)
                        list_mem[i] = list_mem[i+1];
                    list_len = list_len - 1'b1;
                    if (int'(cursor) >= int'(list_len))
                        cursor = '0;
                end
            end
            CMD_READ: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.data_out = list_mem[cursor];
                    nxt = int'(cursor) + 1;
                    cursor = (nxt >= int'(list_len)) ? '0 : CUR_W'(nxt);
                end
            end
            CMD_PEEK: begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                    r.data_out = list_mem[cursor];
            end
            CMD_REWIND: begin
                cursor = '0;
            end
            CMD_CLEAR: begin
                list_len = '0;
                cursor   = '0;
            end
            default: begin
                // unused codes leave the list alone
            end
        endcase
        r.count = list_len;
        return r;
    endfunction

    initial begin
        t_out want;
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        full_seen  = 0;
        empty_seen = 0;
        list_len   = '0;
        cursor     = '0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                list_len = '0;
                cursor   = '0;
                pending_results.delete();
            end else begin
                // retire the result first: it belongs to an older command
                if (out_valid && out_ready) begin
                    if (pending_results.size() == 0) begin
                        $error("unexpected result: data_out %h count %0d status %0d",
                               out_txn.data_out, out_txn.count, out_txn.status);
                        fail_count++;
                    end else begin
                        want = pending_results.pop_front();
                        checked++;
                        if (want.status == ST_FULL)  full_seen++;
                        if (want.status == ST_EMPTY) empty_seen++;
                        if (out_txn.data_out !== want.data_out) begin
                            $error("data_out mismatch: expected %h, actual %h",
                                   want.data_out, out_txn.data_out);
                            fail_count++;
                        end
                        if (out_txn.count !== want.count) begin
                            $error("count mismatch: expected %0d, actual %0d",
                                   want.count, out_txn.count);
                            fail_count++;
                        end
                        if (out_txn.status !== want.status) begin
                            $error("status mismatch: expected %0d, actual %0d",
                                   want.status, out_txn.status);
                            fail_count++;
                        end
                    end
                end
                // queue the prediction at the tail
                if (in_valid && in_ready)
                    pending_results.insert(pending_results.size(), run_list_cmd(in_txn));
                pending = pending_results.size();
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/circular_polling_list_tb.sv =====
`default_nettype none

module circular_polling_list_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cpl_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 900;
    // Longest correct stretch without any transaction is the receiver
    // hold-off below; allow several times that before declaring a hang.
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 2000;
    localparam int GAP_PCT      = 19;

    // Codes the block must ignore.
    localparam logic [IN_CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
    localparam logic [IN_CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

    // Random traffic mixes: grow the list, poll it, or shrink it.
    localparam int MIX_FILL  = 0;
    localparam int MIX_POLL  = 1;
    localparam int MIX_DRAIN = 2;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;

    int cmd_seen [8];

    // Shared between stimulus and receiver: quiet stretch and one long hold-off.
    bit no_gaps     = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_taken  = 1'b0;

    always #5ns i_clk = ~i_clk;

    circular_polling_list #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    cpl_list_checker #(
        .DEPTH (DEPTH)
    ) list_chk (
        .clk        (i_clk),
        .rst_n      (i_rst_n),
        .in_valid   (i_in_valid),
        .in_ready   (o_in_ready),
        .in_txn     (i_in),
        .out_valid  (o_out_valid),
        .out_ready  (i_out_ready),
        .out_txn    (o_out),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .full_seen  (full_seen),
        .empty_seen (empty_seen)
    );

    // Offer one command transaction. Enter and leave at a falling edge;
    // each falling edge gets a single assignment to i_in_valid, so valid
    // stays high across back-to-back transactions.
    task automatic issue_cmd(input logic [IN_CMD_W-1:0] cmd,
                             input logic [IN_DATA_W-1:0] data);
        // insert random idle cycles ahead of the transaction
        if (!no_gaps) begin
            while ($urandom_range(99) < GAP_PCT) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= '{cmd: cmd, data_in: data};
        // hold the payload until the block takes it
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        cmd_seen[cmd]++;
        @(negedge i_clk);
    endtask

    // Mix extremes into otherwise random data words.
    function automatic logic [IN_DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Pick a command according to the current traffic mix.
    function automatic logic [IN_CMD_W-1:0] pick_cmd(int mix);
        int w_app;
        int w_rd;
        int w_pk;
        int w_rm;
        int r;
        case (mix)
            MIX_FILL:  begin w_app = 60; w_rd = 15; w_pk = 8;  w_rm = 8;  end
            MIX_POLL:  begin w_app = 8;  w_rd = 55; w_pk = 15; w_rm = 12; end
            default:   begin w_app = 15; w_rd = 20; w_pk = 10; w_rm = 48; end
        endcase
        r = $urandom_range(99);
        if (r < w_app)                     return CMD_APPEND;
        if (r < w_app + w_rd)              return CMD_READ;
        if (r < w_app + w_rd + w_pk)       return CMD_PEEK;
        if (r < w_app + w_rd + w_pk + w_rm) return CMD_REMOVE;
        if (r < 95)                        return CMD_REWIND;
        if (r < 97)                        return CMD_CLEAR;
        return ($urandom_range(1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    endfunction

    // Receiver: random back-pressure, a quiet stretch, and one long
    // hold-off counted here so the block fills and stalls its input.
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (no_gaps) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= GAP_PCT);
            end
        end
    end

    // Watchdog: abort when no transaction moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("** circular_polling_list: FAILED **");
        $finish;
    end

    initial begin
        int mix;
        int burst_left;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        foreach (cmd_seen[k]) cmd_seen[k] = 0;

        // hold reset, then release it at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every command but append on an empty list
        issue_cmd(CMD_PEEK,   '1);
        issue_cmd(CMD_READ,   '1);
        issue_cmd(CMD_REMOVE, '1);
        issue_cmd(CMD_REWIND, '0);
        issue_cmd(CMD_CLEAR,  '0);
        // unused codes must be ignored
        issue_cmd(CMD_UNUSED_6, '1);
        issue_cmd(CMD_UNUSED_7, 32'h5555_5555);
        // fill the list with extreme and patterned words
        for (int i = 0; i < DEPTH; i++) begin
            case (i)
                0:       issue_cmd(CMD_APPEND, '0);
                1:       issue_cmd(CMD_APPEND, '1);
                2:       issue_cmd(CMD_APPEND, 32'h5555_5555);
                3:       issue_cmd(CMD_APPEND, 32'hAAAA_AAAA);
                4:       issue_cmd(CMD_APPEND, 32'h8000_0001);
                default: issue_cmd(CMD_APPEND, $urandom);
            endcase
        end
        // append to a full list is refused
        issue_cmd(CMD_APPEND, 32'hDEAD_BEEF);
        issue_cmd(CMD_PEEK,   '0);
        issue_cmd(CMD_READ,   '0);
        issue_cmd(CMD_REMOVE, '0);
        issue_cmd(CMD_REWIND, '0);
        issue_cmd(CMD_CLEAR,  '0);

        // Random: bursts of one traffic mix at a time
        mix        = MIX_FILL;
        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                mix        = $urandom_range(2);
                burst_left = $urandom_range(20, 60);
            end
            burst_left--;
            // start the long receiver hold-off while commands keep coming
            if (n == 100)
                hold_req = 1'b1;
            // drop all idling for a stretch on both sides
            no_gaps = (n >= 400 && n < 550);
            issue_cmd(pick_cmd(mix), pick_word());
        end
        i_in_valid <= 1'b0;

        // drain: wait for every expected result before reporting
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);

        $display("Sent %0d append, %0d remove, %0d read, %0d peek, %0d rewind, %0d clear, %0d unused",
                 cmd_seen[CMD_APPEND], cmd_seen[CMD_REMOVE], cmd_seen[CMD_READ],
                 cmd_seen[CMD_PEEK], cmd_seen[CMD_REWIND], cmd_seen[CMD_CLEAR],
                 cmd_seen[CMD_UNUSED_6] + cmd_seen[CMD_UNUSED_7]);
        $display("Checked %0d results: %0d refused appends, %0d commands on an empty list",
                 checked, full_seen, empty_seen);
        if (fail_count == 0) begin
            $display("** circular_polling_list: PASSED **");
        end else begin
            $display("** circular_polling_list: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== circular_polling_list.f =====
+incdir+hdl
hdl/cpl_pkg.sv
hdl/cpl_cell.sv
hdl/circular_polling_list.sv
tb/sv/cpl_list_checker.sv
tb/sv/circular_polling_list_tb.sv
